@@ design/bts_pkg.sv @@
package bts_pkg;

  // Fixed-point format of the sample coordinates
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = FRAC_BITS + 1;
  localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1) << FRAC_BITS;

  // Texture geometry
  localparam int MAX_DIM     = 256;
  localparam int DIM_W       = 9;
  localparam int CELL_W      = 8;
  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int ROW_W       = CELL_W + DIM_W;
  localparam int SCALED_W    = COORD_W + CELL_W;

  // Blend widths
  localparam int CHAN_W  = 8;
  localparam int WEIGHT_W = FRAC_BITS + 1;
  localparam int LERP_W  = CHAN_W + FRAC_BITS;
  localparam int SUM_W   = LERP_W + WEIGHT_W;
  localparam int NCHAN   = 3;
  localparam int NTAP    = 4;

  // Tap order in the read ports
  localparam int TAP_A = 0;
  localparam int TAP_B = 1;
  localparam int TAP_C = 2;
  localparam int TAP_D = 3;

  // Commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIM_W;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0]     DIM_RESET      = DIM_W'(MAX_DIM);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } texel_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    texel_t            data;
  } tex_write_t;

  // Size actually used: clamped to 2..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] n);
    logic [DIM_W-1:0] r;
    r = n;
    if (n < DIM_W'(2)) r = DIM_W'(2);
    else if (n > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] chan_of(input texel_t x, input int k);
    logic [CHAN_W-1:0] r;
    case (k)
      0:       r = x.red;
      1:       r = x.green;
      default: r = x.blue;
    endcase
    return r;
  endfunction

endpackage

@@ design/bts_if.sv @@
interface bts_in_if import bts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [ADDR_W-1:0]  texel_index;
  logic [CHAN_W-1:0]  texel_red;
  logic [CHAN_W-1:0]  texel_green;
  logic [CHAN_W-1:0]  texel_blue;
  logic [COORD_W-1:0] coord_u;
  logic [COORD_W-1:0] coord_v;

  modport source (output valid, cmd, texel_index, texel_red, texel_green, texel_blue,
                  coord_u, coord_v, input ready);
  modport sink (input valid, cmd, texel_index, texel_red, texel_green, texel_blue,
                coord_u, coord_v, output ready);
endinterface

interface bts_out_if import bts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              out_of_range;

  modport source (output valid, out_red, out_green, out_blue, out_of_range, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_of_range, output ready);
endinterface

@@ design/bts_texstore.sv @@
// Texel store: four copies that take every write, one read port per tap
module bts_texstore import bts_pkg::*; (
  input  logic                    clk,
  input  tex_write_t              wr,
  input  logic                    ren,
  input  logic [NTAP-1:0][ADDR_W-1:0] raddr,
  output texel_t [NTAP-1:0]       rdata
);

  for (genvar g = 0; g < NTAP; g++) begin : g_copy
    texel_t mem [STORE_DEPTH];

    always_ff @(posedge clk) begin
      if (wr.en) begin
        mem[wr.addr] <= wr.data;
      end
    end

    always_ff @(posedge clk) begin
      if (ren) begin
        rdata[g] <= mem[raddr[g]];
      end
    end
  end

endmodule

@@ design/bilinear_texture_sampler_unit.sv @@
// Bilinear texture sampler. Takes one request per cycle unless back-pressure from the output
// fills the pipe, texel writes and samples mixed freely, and returns one result per sample
// (none for a write). The work runs through six register stages: request capture, scale,
// cell and row address, texel read from a 64K x 24 store kept as four copies so the four
// neighbours come out in one read, horizontal blend, and vertical blend with rounding into
// the output register. A stall at the output only holds stages that are full; empty stages
// keep filling. The store has no reset: texels must be read only after they are written;
// the block does not enforce this. Width and height must be written on the config port
// only while idle, which the block does not enforce either.
module bilinear_texture_sampler_unit import bts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  bts_in_if.sink                sample_in,
  bts_out_if.source             result_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Config registers
  logic [DIM_W-1:0] tex_width, tex_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= DIM_RESET;
      tex_height <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEX_WIDTH:  tex_width  <= cfg_data;
        REG_TEX_HEIGHT: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0]  w, h;
  logic [CELL_W-1:0] wm1, hm1;
  assign w   = clamp_size(tex_width);
  assign h   = clamp_size(tex_height);
  assign wm1 = CELL_W'(w - DIM_W'(1));
  assign hm1 = CELL_W'(h - DIM_W'(1));

  // Stage enables: a stage loads when it is empty or the next one loads
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  logic en1, en2, en3, en4, en5, en6;
  assign en6 = !s6_valid || result_out.ready;
  assign en5 = !s5_valid || en6;
  assign en4 = !s4_valid || en5;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign sample_in.ready = en1;

  // Stage 1: capture request
  logic               s1_cmd;
  logic [COORD_W-1:0] s1_u, s1_v;
  logic [ADDR_W-1:0]  s1_waddr;
  texel_t             s1_texel;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en1) s1_valid <= sample_in.valid;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_cmd   <= sample_in.cmd;
      s1_u     <= sample_in.coord_u;
      s1_v     <= sample_in.coord_v;
      s1_waddr <= sample_in.texel_index;
      s1_texel <= '{red: sample_in.texel_red, green: sample_in.texel_green,
                    blue: sample_in.texel_blue};
    end
  end

  // Stage 2: scale coordinates by size minus one
  logic                s2_cmd, s2_oor;
  logic [SCALED_W-1:0] s2_su, s2_sv;
  logic [ADDR_W-1:0]   s2_waddr;
  texel_t              s2_texel;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en2) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_cmd   <= s1_cmd;
      s2_oor   <= (s1_u > COORD_ONE) || (s1_v > COORD_ONE);
      s2_su    <= SCALED_W'(s1_u) * SCALED_W'(wm1);
      s2_sv    <= SCALED_W'(s1_v) * SCALED_W'(hm1);
      s2_waddr <= s1_waddr;
      s2_texel <= s1_texel;
    end
  end

  // Stage 3: cell, fraction, neighbour clamp and row base
  logic [CELL_W-1:0]    x0, y0, x1, y1;
  assign x0 = s2_su[FRAC_BITS +: CELL_W];
  assign y0 = s2_sv[FRAC_BITS +: CELL_W];
  assign x1 = (DIM_W'(x0) + DIM_W'(1) < w) ? x0 + CELL_W'(1) : wm1;
  assign y1 = (DIM_W'(y0) + DIM_W'(1) < h) ? y0 + CELL_W'(1) : hm1;

  logic                 s3_cmd, s3_oor;
  logic [CELL_W-1:0]    s3_x0, s3_x1;
  logic [ROW_W-1:0]     s3_row0, s3_row1;
  logic [FRAC_BITS-1:0] s3_s, s3_t;
  logic [ADDR_W-1:0]    s3_waddr;
  texel_t               s3_texel;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en3) s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_cmd   <= s2_cmd;
      s3_oor   <= s2_oor;
      s3_x0    <= x0;
      s3_x1    <= x1;
      s3_row0  <= ROW_W'(y0) * ROW_W'(w);
      s3_row1  <= ROW_W'(y1) * ROW_W'(w);
      s3_s     <= s2_su[FRAC_BITS-1:0];
      s3_t     <= s2_sv[FRAC_BITS-1:0];
      s3_waddr <= s2_waddr;
      s3_texel <= s2_texel;
    end
  end

  // Texel store access: writes and reads both issue from stage 3, in order
  tex_write_t                  tex_wr;
  logic [NTAP-1:0][ADDR_W-1:0] raddr;
  texel_t [NTAP-1:0]           rdata;

  assign tex_wr.en   = s3_valid && (s3_cmd == CMD_WRITE) && en4;
  assign tex_wr.addr = s3_waddr;
  assign tex_wr.data = s3_texel;

  assign raddr[TAP_A] = ADDR_W'(s3_row0 + ROW_W'(s3_x0));
  assign raddr[TAP_B] = ADDR_W'(s3_row0 + ROW_W'(s3_x1));
  assign raddr[TAP_C] = ADDR_W'(s3_row1 + ROW_W'(s3_x1));
  assign raddr[TAP_D] = ADDR_W'(s3_row1 + ROW_W'(s3_x0));

  bts_texstore u_texstore (
    .clk   (clk),
    .wr    (tex_wr),
    .ren   (en4),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Stage 4: texels arrive; writes leave the pipe here
  logic                 s4_oor;
  logic [FRAC_BITS-1:0] s4_s, s4_t;

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (en4) s4_valid <= s3_valid && (s3_cmd == CMD_SAMPLE);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_oor <= s3_oor;
      s4_s   <= s3_s;
      s4_t   <= s3_t;
    end
  end

  // Stage 5: horizontal blend of top and bottom pairs
  logic [WEIGHT_W-1:0]              s_inv;
  logic [NCHAN-1:0][LERP_W-1:0]     top, bot;
  assign s_inv = COORD_ONE - WEIGHT_W'(s4_s);

  always_comb begin
    for (int k = 0; k < NCHAN; k++) begin
      top[k] = LERP_W'(chan_of(rdata[TAP_A], k)) * LERP_W'(s_inv)
             + LERP_W'(chan_of(rdata[TAP_B], k)) * LERP_W'(s4_s);
      bot[k] = LERP_W'(chan_of(rdata[TAP_D], k)) * LERP_W'(s_inv)
             + LERP_W'(chan_of(rdata[TAP_C], k)) * LERP_W'(s4_s);
    end
  end

  logic                         s5_oor;
  logic [FRAC_BITS-1:0]         s5_t;
  logic [NCHAN-1:0][LERP_W-1:0] s5_top, s5_bot;

  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else if (en5) s5_valid <= s4_valid;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_oor <= s4_oor;
      s5_t   <= s4_t;
      s5_top <= top;
      s5_bot <= bot;
    end
  end

  // Stage 6: vertical blend, round half up, saturate; out-of-range samples give zero
  logic [WEIGHT_W-1:0]          t_inv;
  logic [NCHAN-1:0][SUM_W:0]    sum;
  logic [NCHAN-1:0][CHAN_W-1:0] chan_out;
  assign t_inv = COORD_ONE - WEIGHT_W'(s5_t);

  always_comb begin
    for (int k = 0; k < NCHAN; k++) begin
      sum[k] = (SUM_W+1)'(s5_top[k]) * (SUM_W+1)'(t_inv)
             + (SUM_W+1)'(s5_bot[k]) * (SUM_W+1)'(s5_t)
             + ((SUM_W+1)'(1) << (2*FRAC_BITS - 1));
      if (s5_oor) chan_out[k] = '0;
      else if (sum[k][SUM_W:2*FRAC_BITS] > (SUM_W+1-2*FRAC_BITS)'(255)) chan_out[k] = '1;
      else chan_out[k] = sum[k][2*FRAC_BITS +: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s6_valid <= 1'b0;
    else if (en6) s6_valid <= s5_valid;
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      result_out.out_red      <= chan_out[0];
      result_out.out_green    <= chan_out[1];
      result_out.out_blue     <= chan_out[2];
      result_out.out_of_range <= s5_oor;
    end
  end

  assign result_out.valid = s6_valid;

  // Checks
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.out_of_range |->
      (result_out.out_red == '0) && (result_out.out_green == '0) && (result_out.out_blue == '0))
    else $error("out of range result carries colour");

  a_no_write_in_sample: assert property (@(posedge clk) disable iff (rst)
    tex_wr.en |-> en4 && s3_valid && (s3_cmd == CMD_WRITE))
    else $error("store write without a write request in stage 3");

  a_neighbour_in_row: assert property (@(posedge clk) disable iff (rst)
    s3_valid && (s3_cmd == CMD_SAMPLE) && !s3_oor |->
      (s3_x1 >= s3_x0) && (s3_x1 <= wm1) && (s3_row1 >= s3_row0))
    else $error("neighbour outside texture");

  a_held_stage: assert property (@(posedge clk) disable iff (rst)
    s5_valid && !en5 |=> s5_valid && $stable(s5_top) && $stable(s5_bot))
    else $error("stalled blend stage lost its request");

endmodule

@@ verif/bilinear_texture_sampler_unit_tb.sv @@
`timescale 1ns / 1ps

module bilinear_texture_sampler_unit_tb;
  import bts_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE       = 20;
  localparam int RAND_PER_SET = 40;

  typedef struct {
    logic               cmd;
    logic [ADDR_W-1:0]  idx;
    texel_t             tx;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
  } request_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              oor;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TEX_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bts_in_if  sample_in ();
  bts_out_if result_out ();

  bilinear_texture_sampler_unit uut (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_in.sink),
    .result_out(result_out.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the texture and size registers
  texel_t           tex_mirror [STORE_DEPTH];
  logic [DIM_W-1:0] mirror_w = DIM_W'(MAX_DIM);
  logic [DIM_W-1:0] mirror_h = DIM_W'(MAX_DIM);

  // Generator-side view: which texels have been queued for writing
  bit               texel_loaded [STORE_DEPTH];
  logic [DIM_W-1:0] gen_w;
  logic [DIM_W-1:0] gen_h;

  request_t pending_reqs[$];
  color_t   expected_colors[$];
  int       unsent = 0;
  int       errors = 0;
  logic     hold_req = 1'b0;

  function automatic longint used_size(input logic [DIM_W-1:0] n);
    if (n < 2) return 2;
    if (n > MAX_DIM) return MAX_DIM;
    return n;
  endfunction

  // Four neighbor addresses (A, B, C, D) and the fractions of a sample
  function automatic void neighbor_cells(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                                         input logic [DIM_W-1:0] wr, input logic [DIM_W-1:0] hr,
                                         output logic [3:0][ADDR_W-1:0] cells,
                                         output longint s, output longint t);
    longint w, h, su, sv, x0, y0, x1, y1;
    w  = used_size(wr);
    h  = used_size(hr);
    su = longint'(u) * (w - 1);
    sv = longint'(v) * (h - 1);
    x0 = su >> FRAC_BITS;
    y0 = sv >> FRAC_BITS;
    s  = su & 64'hFFFF;
    t  = sv & 64'hFFFF;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    cells[0] = ADDR_W'(y0 * w + x0);
    cells[1] = ADDR_W'(y0 * w + x1);
    cells[2] = ADDR_W'(y1 * w + x1);
    cells[3] = ADDR_W'(y1 * w + x0);
  endfunction

  function automatic logic [CHAN_W-1:0] lerp2d(input longint a, input longint b, input longint c,
                                                input longint d, input longint s, input longint t);
    longint one, top, bot, sum, r;
    one = longint'(1) << FRAC_BITS;
    top = a * (one - s) + b * s;
    bot = d * (one - s) + c * s;
    sum = top * (one - t) + bot * t;
    r   = (sum + (longint'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
    return (r > 255) ? 8'hFF : CHAN_W'(r);
  endfunction

  // Expected color of one sample request
  function automatic color_t predict_color(input request_t rq);
    color_t c;
    logic [3:0][ADDR_W-1:0] cells;
    longint s, t;
    texel_t ta, tb, tc, td;
    c = '0;
    if (rq.u > COORD_ONE || rq.v > COORD_ONE) begin
      c.oor = 1'b1;
      return c;
    end
    neighbor_cells(rq.u, rq.v, mirror_w, mirror_h, cells, s, t);
    ta = tex_mirror[cells[0]];
    tb = tex_mirror[cells[1]];
    tc = tex_mirror[cells[2]];
    td = tex_mirror[cells[3]];
    c.red   = lerp2d(ta.red, tb.red, tc.red, td.red, s, t);
    c.green = lerp2d(ta.green, tb.green, tc.green, td.green, s, t);
    c.blue  = lerp2d(ta.blue, tb.blue, tc.blue, td.blue, s, t);
    return c;
  endfunction

  function automatic texel_t rand_texel();
    texel_t x;
    x = texel_t'($urandom);
    case ($urandom_range(0, 7))
      0: x = '0;
      1: x = '1;
      default: ;
    endcase
    return x;
  endfunction

  task automatic push_write(input logic [ADDR_W-1:0] idx, input texel_t x);
    request_t rq;
    rq.cmd = CMD_WRITE;
    rq.idx = idx;
    rq.tx  = x;
    rq.u   = COORD_W'($urandom);
    rq.v   = COORD_W'($urandom);
    texel_loaded[idx] = 1'b1;
    pending_reqs.push_back(rq);
    unsent++;
  endtask

  // Sample request; neighbors not yet loaded are written first
  task automatic push_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    request_t rq;
    logic [3:0][ADDR_W-1:0] cells;
    longint s, t;
    if (u <= COORD_ONE && v <= COORD_ONE) begin
      neighbor_cells(u, v, gen_w, gen_h, cells, s, t);
      for (int k = 0; k < NTAP; k++)
        if (!texel_loaded[cells[k]]) push_write(cells[k], rand_texel());
    end
    rq.cmd = CMD_SAMPLE;
    rq.idx = ADDR_W'($urandom);
    rq.tx  = texel_t'($urandom);
    rq.u   = u;
    rq.v   = v;
    pending_reqs.push_back(rq);
    unsent++;
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COORD_ONE;
      default: return COORD_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic wait_drained();
    while (unsent > 0 || expected_colors.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TEX_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_TEX_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we   <= 1'b0;
    mirror_w = w;
    mirror_h = h;
    gen_w    = w;
    gen_h    = h;
  endtask

  // Request driver
  int in_gap = 0;
  always @(posedge clk) begin
    request_t rq;
    if (rst) begin
      sample_in.valid <= 1'b0;
    end else if (!sample_in.valid || sample_in.ready) begin
      if (sample_in.valid) begin
        rq.cmd = sample_in.cmd;
        rq.idx = sample_in.texel_index;
        rq.tx  = {sample_in.texel_red, sample_in.texel_green, sample_in.texel_blue};
        rq.u   = sample_in.coord_u;
        rq.v   = sample_in.coord_v;
        if (rq.cmd == CMD_WRITE) tex_mirror[rq.idx] = rq.tx;
        else expected_colors.push_back(predict_color(rq));
        unsent--;
      end
      if (in_gap > 0) begin
        in_gap--;
        sample_in.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        rq = pending_reqs.pop_front();
        sample_in.valid       <= 1'b1;
        sample_in.cmd         <= rq.cmd;
        sample_in.texel_index <= rq.idx;
        sample_in.texel_red   <= rq.tx.red;
        sample_in.texel_green <= rq.tx.green;
        sample_in.texel_blue  <= rq.tx.blue;
        sample_in.coord_u     <= rq.u;
        sample_in.coord_v     <= rq.v;
        in_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      end else begin
        sample_in.valid <= 1'b0;
      end
    end
  end

  // Result monitor and checker
  int  out_stall = 0;
  int  hold_cnt = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    color_t exp_c;
    if (!rst) begin
      if (result_out.valid && result_out.ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d oor=%0d", $time,
                   result_out.out_red, result_out.out_green, result_out.out_blue,
                   result_out.out_of_range);
          errors++;
        end else begin
          exp_c = expected_colors.pop_front();
          if (result_out.out_red !== exp_c.red) begin
            $display("%0t: red expected %0d actual %0d", $time, exp_c.red, result_out.out_red);
            errors++;
          end
          if (result_out.out_green !== exp_c.green) begin
            $display("%0t: green expected %0d actual %0d", $time, exp_c.green,
                     result_out.out_green);
            errors++;
          end
          if (result_out.out_blue !== exp_c.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, exp_c.blue, result_out.out_blue);
            errors++;
          end
          if (result_out.out_of_range !== exp_c.oor) begin
            $display("%0t: out_of_range expected %0d actual %0d", $time, exp_c.oor,
                     result_out.out_of_range);
            errors++;
          end
        end
        out_stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      end
      if (hold_req && !hold_done) begin
        hold_cnt  = HOLD_CYCLES;
        hold_done = 1;
      end
    end
    if (rst) begin
      result_out.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      result_out.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= 1'b1;
    end
  end

  // Watchdog: cycles with no request or result moving
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((sample_in.valid && sample_in.ready) || (result_out.valid && result_out.ready))
      idle_cycles <= 0;
    else if (!rst)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus: directed set, then random sets over several texture sizes
  initial begin
    logic [DIM_W-1:0] widths [6];
    logic [DIM_W-1:0] heights [6];
    int sel;
    widths  = '{9'd256, 9'd2, 9'd0, 9'd511, 9'd5, 9'd17};
    heights = '{9'd256, 9'd2, 9'd511, 9'd1, 9'd7, 9'd3};
    sample_in.valid       = 1'b0;
    sample_in.cmd         = CMD_WRITE;
    sample_in.texel_index = '0;
    sample_in.texel_red   = '0;
    sample_in.texel_green = '0;
    sample_in.texel_blue  = '0;
    sample_in.coord_u     = '0;
    sample_in.coord_v     = '0;
    result_out.ready      = 1'b0;
    gen_w = DIM_W'(MAX_DIM);
    gen_h = DIM_W'(MAX_DIM);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      set_size(widths[ph], heights[ph]);
      if (ph == 0) begin
        // corners, full-scale channels, edge clamp and out-of-range cases
        push_write(16'hFFFF, '1);
        push_write(16'h0000, '0);
        push_write(16'h0001, '1);
        push_write(16'h0100, '1);
        push_write(16'h0101, '1);
        push_sample(17'd0, 17'd0);
        push_sample(COORD_ONE, COORD_ONE);
        push_sample(COORD_ONE, 17'd0);
        push_sample(17'd0, COORD_ONE);
        push_sample(17'd128, 17'd128);
        push_sample(17'd32768, 17'd32768);
        push_sample(17'd65535, 17'd1);
        push_sample(COORD_ONE + 17'd1, 17'd0);
        push_sample(17'd0, 17'h1FFFF);
        push_sample(17'h1FFFF, 17'h1FFFF);
        push_sample(17'h10000 | 17'h0AAAA, 17'h15555);
      end
      if (ph == 2) hold_req <= 1'b1;
      for (int n = 0; n < RAND_PER_SET; n++) begin
        sel = $urandom_range(0, 19);
        if (sel < 4)
          push_write(ADDR_W'($urandom_range(0, used_size(gen_w) * used_size(gen_h) - 1)),
                     rand_texel());
        else if (sel == 4)
          push_write(ADDR_W'($urandom), rand_texel());
        else if (sel == 5)
          push_sample(COORD_W'($urandom_range(65537, 131071)), rand_coord());
        else if (sel == 6)
          push_sample(rand_coord(), COORD_W'($urandom_range(65537, 131071)));
        else
          push_sample(rand_coord(), rand_coord());
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
